/* sv/double_ended_priority_queue_unit_assert.svh */
// Assertion macros used by the queue datapath.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/depq_pkg.sv */
// Package with the item types, codes and controller commands of the queue.
`default_nettype none
package depq_pkg;

  localparam int DEPQ_CAPACITY = 64;
  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT_MAX = 3'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT_MIN = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_KEY_EXISTS  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] result_key;
    logic                    found;
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INS,
    CMD_RD0,
    CMD_RD1,
    CMD_RMV,
    CMD_RDD,
    CMD_DOWN,
    CMD_RDU,
    CMD_UP,
    CMD_PLACE,
    CMD_RDT,
    CMD_MINL,
    CMD_SCAN_RD,
    CMD_SCAN_CMP,
    CMD_FIN
  } dp_cmd_t;

  typedef struct packed {
    logic is_ins;
    logic is_rmv;
    logic is_scan;
    logic err;
    logic cnt_zero;
    logic dmove;
    logic umove;
    logic fix1;
    logic fix2;
    logic scan_end;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/depq_dp.sv */
// Datapath of the queue: heap memories, slot registers, sift compares and result register.
`default_nettype none
`include "double_ended_priority_queue_unit_assert.svh"
module depq_dp import depq_pkg::*; #(
  parameter int CAPACITY = DEPQ_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_item_t   in_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_item_t       out_data
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = SW + 2;

  function automatic logic better(input logic mx, input logic signed [KEY_W-1:0] a,
                                  input logic signed [KEY_W-1:0] b);
    return mx ? (a > b) : (a < b);
  endfunction

  logic signed [KEY_W-1:0] mxk_mem [CAPACITY];
  logic [SW-1:0]           mxt_mem [CAPACITY];
  logic signed [KEY_W-1:0] mnk_mem [CAPACITY];
  logic [SW-1:0]           mnt_mem [CAPACITY];

  logic signed [KEY_W-1:0] mxk_a_r, mxk_b_r, mnk_a_r, mnk_b_r;
  logic [SW-1:0]           mxt_a_r, mxt_b_r, mnt_a_r, mnt_b_r;

  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] key_r, mk_r, mkey2_r, rk_r;
  logic [POS_W-1:0]        pos_r;
  logic [CW-1:0]           cnt_r;
  logic [SW-1:0]           i_r, mt_r, q_r, p_r;
  logic                    sel_max_r, fix1_r, fix2_r, found_r;
  logic [STAT_W-1:0]       status_r;
  out_item_t               out_r;

  logic [SW-1:0]           last, im1, par, p_sel, bs, bt, lt_f;
  logic [XW-1:0]           l_x, r_x;
  logic                    l_ok, r_ok, dmove, umove, rmv_wr, hit;
  logic signed [KEY_W-1:0] ka, kb, bk;
  logic [SW-1:0]           ta, tb;
  logic [SW-1:0]           mx_ra, mx_rb, mn_ra, mn_rb;

  logic                    hk_we, ht_we, ot_we;
  logic [SW-1:0]           hk_wa, ht_wa, ot_wa, ht_wd, ot_wd;
  logic signed [KEY_W-1:0] hk_wd;
  logic                    mxk_we, mnk_we, mxt_we, mnt_we;
  logic [SW-1:0]           mxk_wa, mnk_wa, mxt_wa, mnt_wa, mxt_wd, mnt_wd;
  logic signed [KEY_W-1:0] mxk_wd, mnk_wd;

  assign last  = SW'(cnt_r - 1'b1);
  assign l_x   = {1'b0, i_r, 1'b1};
  assign r_x   = l_x + 1'b1;
  assign l_ok  = l_x < XW'(cnt_r);
  assign r_ok  = r_x < XW'(cnt_r);
  assign im1   = i_r - 1'b1;
  assign par   = im1 >> 1;
  assign ka    = sel_max_r ? mxk_a_r : mnk_a_r;
  assign kb    = sel_max_r ? mxk_b_r : mnk_b_r;
  assign ta    = sel_max_r ? mxt_a_r : mnt_a_r;
  assign tb    = sel_max_r ? mxt_b_r : mnt_b_r;
  assign umove = (i_r != '0) && better(sel_max_r, mk_r, ka);
  assign hit   = (mxk_a_r == key_r);
  assign lt_f  = (mxt_b_r == last) ? mxt_a_r : mxt_b_r;
  assign rmv_wr = (mxt_a_r < last) && (mnt_b_r != last);

  always_comb begin
    case (op_r)
      OP_EXTRACT_MAX: p_sel = '0;
      OP_EXTRACT_MIN: p_sel = mnt_a_r;
      default:        p_sel = SW'(pos_r);
    endcase
  end

  // Pick the child that beats the moving entry; ties keep the earlier slot.
  always_comb begin
    bk = mk_r;
    bt = mt_r;
    bs = i_r;
    dmove = 1'b0;
    if (l_ok && better(sel_max_r, ka, mk_r)) begin
      bk = ka;
      bt = ta;
      bs = SW'(l_x);
      dmove = 1'b1;
    end
    if (r_ok && better(sel_max_r, kb, bk)) begin
      bk = kb;
      bt = tb;
      bs = SW'(r_x);
      dmove = 1'b1;
    end
  end

  always_comb begin
    mx_ra = '0;
    mx_rb = '0;
    mn_ra = '0;
    mn_rb = '0;
    case (cmd)
      CMD_RDD: begin
        if (sel_max_r) begin
          mx_ra = SW'(l_x);
          mx_rb = SW'(r_x);
        end else begin
          mn_ra = SW'(l_x);
          mn_rb = SW'(r_x);
        end
      end
      CMD_RDU: begin
        mx_ra = par;
        mn_ra = par;
      end
      CMD_RD1: begin
        mx_ra = p_sel;
        mx_rb = last;
        mn_rb = last;
      end
      CMD_RDT:     mn_ra = q_r;
      CMD_SCAN_RD: mx_ra = i_r;
      default: ;
    endcase
  end

  // The sifted entry stays in registers; passed entries are written, then it is placed.
  always_comb begin
    hk_we = 1'b0;
    ht_we = 1'b0;
    ot_we = 1'b0;
    hk_wa = i_r;
    ht_wa = i_r;
    hk_wd = mk_r;
    ht_wd = mt_r;
    ot_wa = mt_r;
    ot_wd = i_r;
    case (cmd)
      CMD_DOWN: begin
        hk_we = dmove;
        ht_we = dmove;
        ot_we = dmove;
        hk_wd = bk;
        ht_wd = bt;
        ot_wa = bt;
      end
      CMD_UP: begin
        hk_we = umove;
        ht_we = umove;
        ot_we = umove;
        hk_wd = ka;
        ht_wd = ta;
        ot_wa = ta;
      end
      CMD_PLACE: begin
        hk_we = 1'b1;
        ht_we = 1'b1;
        ot_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    mxk_we = sel_max_r & hk_we;
    mxk_wa = hk_wa;
    mxk_wd = hk_wd;
    mnk_we = !sel_max_r & hk_we;
    mnk_wa = hk_wa;
    mnk_wd = hk_wd;
    mxt_we = sel_max_r ? ht_we : ot_we;
    mxt_wa = sel_max_r ? ht_wa : ot_wa;
    mxt_wd = sel_max_r ? ht_wd : ot_wd;
    mnt_we = sel_max_r ? ot_we : ht_we;
    mnt_wa = sel_max_r ? ot_wa : ht_wa;
    mnt_wd = sel_max_r ? ot_wd : ht_wd;
    // The last min entry moves into the vacated min slot; link it both ways.
    if (cmd == CMD_RMV) begin
      mxt_we = rmv_wr;
      mxt_wa = mnt_b_r;
      mxt_wd = mxt_a_r;
      mnt_we = rmv_wr;
      mnt_wa = mxt_a_r;
      mnt_wd = mnt_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mxk_we) mxk_mem[mxk_wa] <= mxk_wd;
    if (mxt_we) mxt_mem[mxt_wa] <= mxt_wd;
    if (mnk_we) mnk_mem[mnk_wa] <= mnk_wd;
    if (mnt_we) mnt_mem[mnt_wa] <= mnt_wd;
    mxk_a_r <= mxk_mem[mx_ra];
    mxk_b_r <= mxk_mem[mx_rb];
    mxt_a_r <= mxt_mem[mx_ra];
    mxt_b_r <= mxt_mem[mx_rb];
    mnk_a_r <= mnk_mem[mn_ra];
    mnk_b_r <= mnk_mem[mn_rb];
    mnt_a_r <= mnt_mem[mn_ra];
    mnt_b_r <= mnt_mem[mn_rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fix1_r <= 1'b0;
      fix2_r <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          op_r    <= in_data.op;
          key_r   <= in_data.key;
          pos_r   <= in_data.position;
          found_r <= 1'b0;
          rk_r    <= '0;
          i_r     <= '0;
          fix1_r  <= 1'b0;
          fix2_r  <= 1'b0;
          status_r <= ST_OK;
          if (in_data.op == OP_INSERT) begin
            if (cnt_r >= CW'(CAPACITY)) status_r <= ST_FULL;
          end else if (in_data.op == OP_EXTRACT_MAX || in_data.op == OP_EXTRACT_MIN ||
                       in_data.op == OP_DELETE_POS) begin
            if (cnt_r == '0) status_r <= ST_EMPTY;
            else if (in_data.op == OP_DELETE_POS &&
                     int'(in_data.position) >= int'(cnt_r)) status_r <= ST_RANGE;
          end
        end
        CMD_INS: begin
          i_r       <= SW'(cnt_r);
          mk_r      <= key_r;
          mt_r      <= SW'(cnt_r);
          sel_max_r <= 1'b1;
          cnt_r     <= cnt_r + 1'b1;
          fix2_r    <= 1'b1;
          q_r       <= SW'(cnt_r);
          mkey2_r   <= key_r;
        end
        CMD_RD1: p_r <= p_sel;
        CMD_RMV: begin
          rk_r      <= mxk_a_r;
          cnt_r     <= cnt_r - 1'b1;
          i_r       <= p_r;
          mk_r      <= mxk_b_r;
          mt_r      <= lt_f;
          sel_max_r <= 1'b1;
          fix1_r    <= p_r < last;
          fix2_r    <= mxt_a_r < last;
          q_r       <= mxt_a_r;
          mkey2_r   <= mnk_b_r;
        end
        CMD_DOWN: if (dmove) i_r <= bs;
        CMD_UP:   if (umove) i_r <= par;
        CMD_MINL: begin
          sel_max_r <= 1'b0;
          i_r       <= q_r;
          mk_r      <= mkey2_r;
          mt_r      <= mnt_a_r;
          fix2_r    <= 1'b0;
        end
        CMD_SCAN_CMP: begin
          found_r <= hit;
          i_r     <= i_r + 1'b1;
        end
        CMD_FIN: begin
          out_r.result_key <= rk_r;
          out_r.found      <= found_r;
          out_r.status     <= status_r;
          out_r.count      <= COUNT_W'(cnt_r);
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_r;

  always_comb begin
    status.is_ins   = (op_r == OP_INSERT);
    status.is_rmv   = (op_r == OP_EXTRACT_MAX) || (op_r == OP_EXTRACT_MIN) ||
                      (op_r == OP_DELETE_POS);
    status.is_scan  = (op_r == OP_KEY_EXISTS);
    status.err      = (status_r != ST_OK);
    status.cnt_zero = (cnt_r == '0);
    status.dmove    = dmove;
    status.umove    = umove;
    status.fix1     = fix1_r;
    status.fix2     = fix2_r;
    status.scan_end = hit || ((CW'(i_r) + 1'b1) >= cnt_r);
  end

  `DEPQ_ASSERT_NEXT(a_down_deeper, (cmd == CMD_DOWN) && dmove, i_r > $past(i_r), "sift down did not descend")
  `DEPQ_ASSERT_NEXT(a_up_shallower, (cmd == CMD_UP) && umove, i_r < $past(i_r), "sift up did not ascend")
  `DEPQ_ASSERT_NEXT(a_ins_count, cmd == CMD_INS, cnt_r == $past(cnt_r) + 1'b1, "insert did not count")
  `DEPQ_ASSERT_SAME(a_ins_room, cmd == CMD_INS, cnt_r < CW'(CAPACITY), "insert into a full queue")

endmodule
`default_nettype wire

/* sv/depq_ctrl.sv */
// Controller state machine that sequences load, insert and removal setup, both sifts, scan and result.
`default_nettype none
module depq_ctrl import depq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t   cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_DISP  = 17'h00002,
    S_INS   = 17'h00004,
    S_RD0   = 17'h00008,
    S_RD1   = 17'h00010,
    S_RMV   = 17'h00020,
    S_BR    = 17'h00040,
    S_RDD   = 17'h00080,
    S_DOWN  = 17'h00100,
    S_RDU   = 17'h00200,
    S_UP    = 17'h00400,
    S_PLACE = 17'h00800,
    S_RDT   = 17'h01000,
    S_MINL  = 17'h02000,
    S_SCAN  = 17'h04000,
    S_SCANC = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (status.err) state_nxt = S_DONE;
        else if (status.is_ins) state_nxt = S_INS;
        else if (status.is_rmv) state_nxt = S_RD0;
        else if (status.is_scan && !status.cnt_zero) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_INS: begin
        cmd = CMD_INS;
        state_nxt = S_RDD;
      end
      S_RD0: begin
        cmd = CMD_RD0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd = CMD_RD1;
        state_nxt = S_RMV;
      end
      S_RMV: begin
        cmd = CMD_RMV;
        state_nxt = S_BR;
      end
      S_BR: begin
        if (status.fix1) state_nxt = S_RDD;
        else if (status.fix2) state_nxt = S_RDT;
        else state_nxt = S_DONE;
      end
      S_RDD: begin
        cmd = CMD_RDD;
        state_nxt = S_DOWN;
      end
      S_DOWN: begin
        cmd = CMD_DOWN;
        state_nxt = status.dmove ? S_RDD : S_RDU;
      end
      S_RDU: begin
        cmd = CMD_RDU;
        state_nxt = S_UP;
      end
      S_UP: begin
        cmd = CMD_UP;
        state_nxt = status.umove ? S_RDU : S_PLACE;
      end
      S_PLACE: begin
        cmd = CMD_PLACE;
        state_nxt = status.fix2 ? S_RDT : S_DONE;
      end
      S_RDT: begin
        cmd = CMD_RDT;
        state_nxt = S_MINL;
      end
      S_MINL: begin
        cmd = CMD_MINL;
        state_nxt = S_RDD;
      end
      S_SCAN: begin
        cmd = CMD_SCAN_RD;
        state_nxt = S_SCANC;
      end
      S_SCANC: begin
        cmd = CMD_SCAN_CMP;
        state_nxt = status.scan_end ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        // Wait here only while the previous item still sits in the output register.
        if (!out_valid_r || out_ready) begin
          cmd = CMD_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd == CMD_FIN) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/double_ended_priority_queue_unit.sv */
// Top level of the double-ended priority queue built from twin max and min heaps.
// Usage:
//   Items arrive on in_valid/in_ready/in_data (op, key, position) and each one
//   yields exactly one result item on out_valid/out_ready/out_data.
//   One item is worked on at a time; in_ready is high only while the
//   controller is idle. Each sift step is a registered memory read followed
//   by a compare and write. An insert sifts its key in the max heap and then
//   in the min heap; a removal sifts the moved last entry in each heap.
//   A key query scans the max heap slot by slot until a hit or the last key.
//   Error cases (full, empty, position out of range) and unknown ops go
//   straight from dispatch to the result.
//   Results sit in an output register, so the next item is accepted while
//   a result waits; if the receiver stalls, the block then holds the second
//   result in its final state until the register frees up.
//   Synchronous reset empties the queue; heap memories are not cleared since
//   only slots below the count are ever used.
`default_nettype none
module double_ended_priority_queue_unit import depq_pkg::*; #(
  parameter int CAPACITY = DEPQ_CAPACITY
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  depq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  depq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

/* test/double_ended_priority_queue_unit_test.sv */
// Self-checking bench for the twin-heap double-ended priority queue unit.
`default_nettype none
module double_ended_priority_queue_unit_test;
  import depq_pkg::*;

  localparam int CAP = DEPQ_CAPACITY;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 610;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  double_ended_priority_queue_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow copy of both heaps and the twin links.
  logic signed [KEY_W-1:0] hi_keys [CAP];
  logic [POS_W-1:0]        hi_twin [CAP];
  logic signed [KEY_W-1:0] lo_keys [CAP];
  logic [POS_W-1:0]        lo_twin [CAP];
  int unsigned             fill;

  out_item_t pending_results [$];
  int  mismatches;
  int  idle_cycles;
  bit  quiet;
  bit  hold_receiver;

  typedef struct {
    in_item_t  item;
    bit        has_result;
    out_item_t result;
  } row_t;
  row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void hi_swap(int a, int b);
    logic signed [KEY_W-1:0] k;
    logic [POS_W-1:0] t;
    lo_twin[hi_twin[a]] = POS_W'(b);
    lo_twin[hi_twin[b]] = POS_W'(a);
    k = hi_keys[a]; hi_keys[a] = hi_keys[b]; hi_keys[b] = k;
    t = hi_twin[a]; hi_twin[a] = hi_twin[b]; hi_twin[b] = t;
  endfunction

  function automatic void lo_swap(int a, int b);
    logic signed [KEY_W-1:0] k;
    logic [POS_W-1:0] t;
    hi_twin[lo_twin[a]] = POS_W'(b);
    hi_twin[lo_twin[b]] = POS_W'(a);
    k = lo_keys[a]; lo_keys[a] = lo_keys[b]; lo_keys[b] = k;
    t = lo_twin[a]; lo_twin[a] = lo_twin[b]; lo_twin[b] = t;
  endfunction

  function automatic void restore_hi(int s);
    int i, l, r, best;
    i = s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      best = i;
      if (l < fill && hi_keys[l] > hi_keys[best]) best = l;
      if (r < fill && hi_keys[r] > hi_keys[best]) best = r;
      if (best == i) break;
      hi_swap(i, best);
      i = best;
    end
    while (i > 0 && hi_keys[(i - 1) / 2] < hi_keys[i]) begin
      hi_swap(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic void restore_lo(int s);
    int i, l, r, best;
    i = s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      best = i;
      if (l < fill && lo_keys[l] < lo_keys[best]) best = l;
      if (r < fill && lo_keys[r] < lo_keys[best]) best = r;
      if (best == i) break;
      lo_swap(i, best);
      i = best;
    end
    while (i > 0 && lo_keys[(i - 1) / 2] > lo_keys[i]) begin
      lo_swap(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic logic signed [KEY_W-1:0] take_entry(int p);
    logic signed [KEY_W-1:0] k;
    int q, last;
    k = hi_keys[p];
    q = hi_twin[p];
    last = fill - 1;
    hi_swap(p, last);
    lo_swap(q, last);
    fill = last;
    if (p < fill) restore_hi(p);
    if (q < fill) restore_lo(q);
    return k;
  endfunction

  function automatic out_item_t predict_queue_op(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.op)
      OP_INSERT: begin
        if (fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          hi_keys[fill] = it.key; hi_twin[fill] = POS_W'(fill);
          lo_keys[fill] = it.key; lo_twin[fill] = POS_W'(fill);
          fill++;
          restore_hi(fill - 1);
          restore_lo(fill - 1);
        end
      end
      OP_EXTRACT_MAX, OP_EXTRACT_MIN, OP_DELETE_POS: begin
        if (fill == 0) r.status = ST_EMPTY;
        else if (it.op == OP_EXTRACT_MAX) r.result_key = take_entry(0);
        else if (it.op == OP_EXTRACT_MIN) r.result_key = take_entry(lo_twin[0]);
        else if (it.position >= fill) r.status = ST_RANGE;
        else r.result_key = take_entry(it.position);
      end
      OP_KEY_EXISTS: begin
        for (int i = 0; i < fill; i++)
          if (hi_keys[i] == it.key) begin
            r.found = 1'b1;
            break;
          end
      end
      default: ;
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
                                         logic [POS_W-1:0] pos);
    in_item_t it;
    it.op = op;
    it.key = key;
    it.position = pos;
    return it;
  endfunction

  function automatic out_item_t make_result(logic signed [KEY_W-1:0] k, logic f,
                                            logic [STAT_W-1:0] st, int c);
    out_item_t r;
    r.result_key = k;
    r.found = f;
    r.status = st;
    r.count = COUNT_W'(c);
    return r;
  endfunction

  task automatic add_row(in_item_t it, bit known, out_item_t res);
    row_t rw;
    rw.item = it;
    rw.has_result = known;
    rw.result = res;
    directed_rows.push_back(rw);
  endtask

  // Keys are mostly drawn from a small pool so duplicates and hits are common.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed(32'($urandom_range(0, 40)) - 32'd20);
    endcase
  endfunction

  // Called at a falling edge; valid stays high between back-to-back items.
  task automatic send_item(in_item_t it, bit known, out_item_t res);
    out_item_t pred;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pred = predict_queue_op(it);
    if (known && pred !== res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch: typed %p predictor %p", res, pred);
    end
    pending_results.push_back(pred);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready <= 1'b0;
        gap = 300;
        while (gap > 0) begin
          @(negedge clk);
          gap--;
        end
        hold_receiver = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_key !== want.result_key || out_data.found !== want.found ||
            out_data.status !== want.status || out_data.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    int r, tail;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    fill = 0;
    mismatches = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_receiver = 1'b0;

    // Directed table: empty-queue and range errors, extremes, ties, unknown ops.
    add_row(make_item(OP_EXTRACT_MAX, 0, 0), 1, make_result(0, 0, ST_EMPTY, 0));
    add_row(make_item(OP_EXTRACT_MIN, 0, 0), 1, make_result(0, 0, ST_EMPTY, 0));
    add_row(make_item(OP_DELETE_POS, 0, 63), 1, make_result(0, 0, ST_EMPTY, 0));
    add_row(make_item(OP_KEY_EXISTS, 5, 0), 1, make_result(0, 0, ST_OK, 0));
    add_row(make_item(OP_INSERT, 32'sh7FFFFFFF, 63), 1, make_result(0, 0, ST_OK, 1));
    add_row(make_item(OP_INSERT, 32'sh80000000, 0), 1, make_result(0, 0, ST_OK, 2));
    add_row(make_item(OP_INSERT, 7, 0), 0, '0);
    add_row(make_item(OP_INSERT, 7, 0), 0, '0);
    add_row(make_item(OP_INSERT, -1, 0), 0, '0);
    add_row(make_item(OP_KEY_EXISTS, 32'sh80000000, 0), 1, make_result(0, 1, ST_OK, 5));
    add_row(make_item(OP_KEY_EXISTS, 8, 0), 1, make_result(0, 0, ST_OK, 5));
    add_row(make_item(OP_DELETE_POS, 0, 5), 1, make_result(0, 0, ST_RANGE, 5));
    add_row(make_item(OP_DELETE_POS, 0, 63), 1, make_result(0, 0, ST_RANGE, 5));
    add_row(make_item(3'd5, -1, 63), 1, make_result(0, 0, ST_OK, 5));
    add_row(make_item(3'd6, 0, 0), 1, make_result(0, 0, ST_OK, 5));
    add_row(make_item(3'd7, 0, 0), 1, make_result(0, 0, ST_OK, 5));
    add_row(make_item(OP_EXTRACT_MAX, 0, 0), 1, make_result(32'sh7FFFFFFF, 0, ST_OK, 4));
    add_row(make_item(OP_EXTRACT_MIN, 0, 0), 1, make_result(32'sh80000000, 0, ST_OK, 3));
    add_row(make_item(OP_DELETE_POS, 0, 2), 0, '0);
    add_row(make_item(OP_DELETE_POS, 0, 0), 0, '0);
    add_row(make_item(OP_EXTRACT_MIN, 0, 0), 0, '0);
    add_row(make_item(OP_EXTRACT_MAX, 0, 0), 1, make_result(0, 0, ST_EMPTY, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].has_result, directed_rows[i].result);

    // Fill to capacity while the receiver holds off, then probe the full case.
    hold_receiver = 1'b1;
    for (int i = 0; i < CAP; i++) send_item(make_item(OP_INSERT, pick_key(), 6'($urandom)),
                                            0, '0);
    send_item(make_item(OP_INSERT, 1, 0), 1, make_result(0, 0, ST_FULL, CAP));
    send_item(make_item(OP_DELETE_POS, 0, 63), 0, '0);

    // Random phase, biased toward inserts in alternate stretches of a hundred items.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n >= NUM_RANDOM - 80) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if ((n / 100) % 2 == 0) r = (r < 55) ? 0 : r;
      if (r < 35) it = make_item(OP_INSERT, pick_key(), 6'($urandom));
      else if (r < 50) it = make_item(OP_EXTRACT_MAX, pick_key(), 6'($urandom));
      else if (r < 65) it = make_item(OP_EXTRACT_MIN, pick_key(), 6'($urandom));
      else if (r < 80)
        it = make_item(OP_DELETE_POS, pick_key(),
                       6'($urandom_range(0, fill > 0 ? fill : 0)) | ($urandom_range(0, 7) == 0 ?
                       6'($urandom) : 6'd0));
      else if (r < 96) it = make_item(OP_KEY_EXISTS, pick_key(), 6'($urandom));
      else it = make_item(3'($urandom_range(5, 7)), pick_key(), 6'($urandom));
      send_item(it, 0, '0);
    end
    in_valid <= 1'b0;

    tail = 0;
    while (pending_results.size() != 0 && tail < WATCHDOG_LIMIT) begin
      @(posedge clk);
      tail++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
